// File: src/dkrs_pkg.sv
package dkrs_pkg;

  localparam int DKRS_MAX_RECORDS = 32;

  localparam int YEAR_W = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W = 5;
  localparam int TAG_W = 8;
  localparam int POS_W = 6;
  localparam int KEY_W = YEAR_W + MONTH_W + DAY_W;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [TAG_W-1:0]   tag;
  } rec_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic drain;
  } cell_ctl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  function automatic logic [KEY_W-1:0] rec_key(input rec_t r);
    rec_key = {r.year, r.month, r.day};
  endfunction

endpackage

// File: src/dkrs_channels.sv
interface dkrs_in_if;
  logic                       valid;
  logic                       ready;
  logic [dkrs_pkg::YEAR_W-1:0]  year;
  logic [dkrs_pkg::MONTH_W-1:0] month;
  logic [dkrs_pkg::DAY_W-1:0]   day;
  logic [dkrs_pkg::TAG_W-1:0]   record_tag;
  logic                       batch_last;

  modport source (output valid, year, month, day, record_tag, batch_last, input ready);
  modport sink (input valid, year, month, day, record_tag, batch_last, output ready);
endinterface

interface dkrs_out_if;
  logic                       valid;
  logic                       ready;
  logic [dkrs_pkg::YEAR_W-1:0]  out_year;
  logic [dkrs_pkg::MONTH_W-1:0] out_month;
  logic [dkrs_pkg::DAY_W-1:0]   out_day;
  logic [dkrs_pkg::TAG_W-1:0]   out_tag;
  logic [dkrs_pkg::POS_W-1:0]   position;
  logic                       overflowed;
  logic                       run_last;

  modport source (output valid, out_year, out_month, out_day, out_tag, position,
                  overflowed, run_last, input ready);
  modport sink (input valid, out_year, out_month, out_day, out_tag, position,
                overflowed, run_last, output ready);
endinterface

// File: src/dkrs_cell.sv
module dkrs_cell (
  input  logic                clk,
  input  dkrs_pkg::cell_ctl_t ctl,
  input  dkrs_pkg::rec_t      new_rec,
  input  dkrs_pkg::rec_t      left_rec,
  input  dkrs_pkg::rec_t      right_rec,
  input  logic                left_gt,
  input  logic                occ,
  output dkrs_pkg::rec_t      rec,
  output logic                gt
);
  import dkrs_pkg::*;

  rec_t rec_r;
  rec_t rec_nxt;

  // Strict compare keeps equal keys in arrival order.
  assign gt  = !occ || (rec_key(rec_r) > rec_key(new_rec));
  assign rec = rec_r;

  always_comb begin
    rec_nxt = rec_r;
    if (ctl.drain) begin
      rec_nxt = right_rec;
    end else if (ctl.insert) begin
      if (left_gt) begin
        rec_nxt = left_rec;
      end else if (gt) begin
        rec_nxt = new_rec;
      end
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

endmodule

// File: src/date_key_record_sorter_unit.sv
// Channel | Dir | Fields                                          | Handshake
// in_ch   | in  | year, month, day, record_tag, batch_last        | valid/ready
// out_ch  | out | out_year, out_month, out_day, out_tag, position, | valid/ready
//         |     | overflowed, run_last                            |
//
// Load: one record per cycle; each beat is inserted into the sorted cell chain
// in the cycle it is accepted. Records past MAX_RECORDS are dropped and flagged.
// Drain: after the batch_last beat, one result beat per stored record follows, one per cycle while
// out_ch.ready is high; in_ch.ready stays low until the last result is taken.
// Reset (rst_n low, synchronous) empties the chain and clears the drop flag.
// A stalled output holds cell 0 and the position counter unchanged.
module date_key_record_sorter_unit #(
  parameter int MAX_RECORDS = dkrs_pkg::DKRS_MAX_RECORDS
) (
  input  logic       clk,
  input  logic       rst_n,
  dkrs_in_if.sink    in_ch,
  dkrs_out_if.source out_ch
);
  import dkrs_pkg::*;

  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  state_t           state_r;
  state_t           state_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             drop_r;
  logic             drop_nxt;
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;

  logic      in_fire;
  logic      out_fire;
  logic      full;
  cell_ctl_t ctl;
  rec_t      new_rec;

  rec_t rec_q [MAX_RECORDS];
  logic [MAX_RECORDS-1:0] gt;
  logic [MAX_RECORDS-1:0] occ;

  assign in_ch.ready = (state_r == ST_LOAD);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;
  assign full        = (count_r == CNT_W'(MAX_RECORDS));

  assign new_rec.year  = in_ch.year;
  assign new_rec.month = in_ch.month;
  assign new_rec.day   = in_ch.day;
  assign new_rec.tag   = in_ch.record_tag;

  // Broadcast command: insert on an accepted beat with room, shift left on a taken result.
  assign ctl.insert = in_fire && !full;
  assign ctl.drain  = out_fire;

  // Cell chain: cell 0 holds the smallest key; occupied cells form a prefix.
  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    assign occ[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      dkrs_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .new_rec  (new_rec),
        .left_rec (new_rec),
        .right_rec(rec_q[(MAX_RECORDS > 1) ? 1 : 0]),
        .left_gt  (1'b0),
        .occ      (occ[i]),
        .rec      (rec_q[i]),
        .gt       (gt[i])
      );
    end else if (i == MAX_RECORDS - 1) begin : g_tail
      dkrs_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .new_rec  (new_rec),
        .left_rec (rec_q[i-1]),
        .right_rec(rec_q[i]),
        .left_gt  (gt[i-1]),
        .occ      (occ[i]),
        .rec      (rec_q[i]),
        .gt       (gt[i])
      );
    end else begin : g_mid
      dkrs_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .new_rec  (new_rec),
        .left_rec (rec_q[i-1]),
        .right_rec(rec_q[i+1]),
        .left_gt  (gt[i-1]),
        .occ      (occ[i]),
        .rec      (rec_q[i]),
        .gt       (gt[i])
      );
    end
  end

  // Result beat comes straight from cell 0's register.
  assign out_ch.valid      = (state_r == ST_DRAIN);
  assign out_ch.out_year   = rec_q[0].year;
  assign out_ch.out_month  = rec_q[0].month;
  assign out_ch.out_day    = rec_q[0].day;
  assign out_ch.out_tag    = rec_q[0].tag;
  assign out_ch.position   = pos_r;
  assign out_ch.overflowed = drop_r;
  assign out_ch.run_last   = (count_r == CNT_W'(1));

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    drop_nxt  = drop_r;
    pos_nxt   = pos_r;
    case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          // Store the beat if room is left, otherwise drop it and flag the batch.
          if (full) begin
            drop_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_ch.batch_last) begin
            state_nxt = ST_DRAIN;
            pos_nxt   = POS_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (out_fire) begin
          count_nxt = count_r - CNT_W'(1);
          pos_nxt   = pos_r + POS_W'(1);
          if (count_r == CNT_W'(1)) begin
            state_nxt = ST_LOAD;
            drop_nxt  = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      drop_r  <= 1'b0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

// File: src/dkrs_checker.sv
module dkrs_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_batch_last,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [dkrs_pkg::POS_W-1:0] out_position,
  input logic                       out_run_last,
  input logic [dkrs_pkg::TAG_W-1:0] out_tag
);
  import dkrs_pkg::*;

  // Load and drain never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while results pending");

  // Final beat of a batch starts the drain.
  a_drain_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_batch_last) |=> out_valid)
    else $error("no result after batch_last");

  // Positions count up by one within a run.
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_run_last) |=>
      (out_valid && out_position == $past(out_position) + POS_W'(1)))
    else $error("position did not advance");

  // Run ends after the beat marked run_last.
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_run_last) |=> (!out_valid && in_ready))
    else $error("results continue past run_last");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_tag) && $stable(out_position)))
    else $error("stalled result changed");

endmodule

bind date_key_record_sorter_unit dkrs_checker u_dkrs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_batch_last(in_ch.batch_last),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_position (out_ch.position),
  .out_run_last (out_ch.run_last),
  .out_tag      (out_ch.out_tag)
);
